FILE: src/per_flow_window_byte_sum_unit_macros.svh
// Assertion macros for the per-flow window byte sum unit.
`ifndef PER_FLOW_WINDOW_BYTE_SUM_UNIT_MACROS_SVH
`define PER_FLOW_WINDOW_BYTE_SUM_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PFW_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PFW_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define PFW_ASSERT(label, clk, rst_n, prop)
`define PFW_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

FILE: src/pfwbs_pkg.sv
// Shared types and constants of the per-flow window byte sum unit.
package pfwbs_pkg;
  localparam int unsigned IdW   = 32;
  localparam int unsigned SumW  = 35;
  localparam int unsigned FillW = 4;
  localparam int unsigned KindW = 2;

  typedef enum logic [KindW-1:0] {
    KIND_UPDATE = 2'd0,
    KIND_EVICT  = 2'd1,
    KIND_DROP   = 2'd2
  } kind_e;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_SCAN   = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_SCAN,
    ST_EMIT,
    ST_DROP
  } state_e;

  typedef struct packed {
    logic   load;      // capture input word
    logic   lookup;    // register match/free search
    logic   update;    // write sample and sums
    logic   scan_pick; // register minimum marked entry
    logic   evict;     // clear picked entry
  } cmd_t;

  typedef struct packed {
    logic   is_scan;
    logic   hit;
    logic   free_found;
    logic   any_marked;
  } sts_t;
endpackage

FILE: src/pfwbs_if.sv
// Valid/ready channel interfaces for samples and results.
interface pfwbs_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] flow_id;
  logic [31:0] read_bytes;
  logic [31:0] write_bytes;
  modport source (output valid, action, flow_id, read_bytes, write_bytes, input ready);
  modport sink   (input valid, action, flow_id, read_bytes, write_bytes, output ready);
endinterface

interface pfwbs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] flow_out;
  logic [34:0] read_sum;
  logic [34:0] write_sum;
  logic [3:0]  fill_count;
  logic        last;
  modport source (output valid, kind, flow_out, read_sum, write_sum, fill_count, last,
                  input ready);
  modport sink   (input valid, kind, flow_out, read_sum, write_sum, fill_count, last,
                  output ready);
endinterface

FILE: src/per_flow_window_byte_sum_unit.sv
// Top level of the per-flow window byte sum unit.
//
// Input channel in_if carries words: action, flow_id, read_bytes, write_bytes.
// A sample word (action 0) finds or allocates its flow and yields one result:
// a window update with the new sums and fill count, or a drop when the table
// is full. A scan word (action 1) evicts every flow whose idle count is at
// most zero, one result per flow in ascending flow id, last set on the final
// one; a scan with nothing to evict yields no result.
// A sample word passes the lookup state, which searches all entry keys,
// then the update state, which writes the ring memory, or the drop state.
// A scan repeats the lookup and scan states, and the emit state for each
// evicted flow, the minimum-key search redone after each eviction; a scan
// with nothing to evict returns to idle from the scan state.
// The unit takes a new word only when the previous one has produced all
// its results.
// Reset clears all entry valid bits and the controller; the ring memories
// hold no reset and are read only after written.
// When the receiver stalls, the result word holds in the output register
// and the controller waits before producing the next.
module per_flow_window_byte_sum_unit #(
  parameter int unsigned WINDOW        = 8,
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  pfwbs_in_if.sink   in_if,
  pfwbs_out_if.source out_if
);
  import pfwbs_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic emit;

  pfwbs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_i(out_if.valid),
    .out_ready_i(out_if.ready),
    .sts_i(sts), .cmd_o(cmd), .emit_o(emit));

  pfwbs_dp #(.Window(WINDOW), .Entries(TABLE_ENTRIES)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .emit_i(emit), .sts_o(sts),
    .in_action_i     (in_if.action),
    .in_flow_id_i    (in_if.flow_id),
    .in_read_bytes_i (in_if.read_bytes),
    .in_write_bytes_i(in_if.write_bytes),
    .out_ready_i     (out_if.ready),
    .out_valid_o     (out_if.valid),
    .out_kind_o      (out_if.kind),
    .out_flow_o      (out_if.flow_out),
    .out_read_sum_o  (out_if.read_sum),
    .out_write_sum_o (out_if.write_sum),
    .out_fill_o      (out_if.fill_count),
    .out_last_o      (out_if.last));
endmodule

FILE: src/pfwbs_ram.sv
// Generic single-port RAM with registered read.
module pfwbs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write and read one address per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: src/pfwbs_ctrl.sv
// Controller state machine of the per-flow window byte sum unit.
module pfwbs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  pfwbs_pkg::sts_t sts_i,
  output pfwbs_pkg::cmd_t cmd_o,
  output logic            emit_o
);
  import pfwbs_pkg::*;
  `include "per_flow_window_byte_sum_unit_macros.svh"

  state_e state_q, state_d;
  logic   slot_free;

  // output register is free or drains this cycle
  assign slot_free = !out_valid_i || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    emit_o     = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (sts_i.is_scan) begin
          cmd_o.scan_pick = 1'b1;
          state_d = ST_SCAN;
        end else begin
          cmd_o.lookup = 1'b1;
          state_d = (sts_i.hit || sts_i.free_found) ? ST_UPDATE : ST_DROP;
        end
      end
      ST_UPDATE: begin
        if (slot_free) begin
          cmd_o.update = 1'b1;
          emit_o       = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_DROP: begin
        if (slot_free) begin
          emit_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        state_d = sts_i.any_marked ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (slot_free) begin
          emit_o      = 1'b1;
          cmd_o.evict = 1'b1;
          state_d     = ST_LOOKUP;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `PFW_ASSERT(a_ready_idle, clk_i, rst_ni, in_ready_o |-> state_q == ST_IDLE)
  `PFW_ASSERT(a_emit_room, clk_i, rst_ni, emit_o |-> slot_free)
  `PFW_ASSERT_NEXT(a_load_lookup, clk_i, rst_ni, cmd_o.load, state_q == ST_LOOKUP)
endmodule

FILE: src/pfwbs_dp.sv
// Datapath: flow table, sample rings, sums and result register.
module pfwbs_dp #(
  parameter int unsigned Window  = 8,
  parameter int unsigned Entries = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pfwbs_pkg::cmd_t              cmd_i,
  input  logic                         emit_i,
  output pfwbs_pkg::sts_t              sts_o,
  input  logic                         in_action_i,
  input  logic [pfwbs_pkg::IdW-1:0]    in_flow_id_i,
  input  logic [31:0]                  in_read_bytes_i,
  input  logic [31:0]                  in_write_bytes_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [pfwbs_pkg::KindW-1:0]  out_kind_o,
  output logic [pfwbs_pkg::IdW-1:0]    out_flow_o,
  output logic [pfwbs_pkg::SumW-1:0]   out_read_sum_o,
  output logic [pfwbs_pkg::SumW-1:0]   out_write_sum_o,
  output logic [pfwbs_pkg::FillW-1:0]  out_fill_o,
  output logic                         out_last_o
);
  import pfwbs_pkg::*;
  `include "per_flow_window_byte_sum_unit_macros.svh"

  localparam int unsigned EW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned HW = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned RingDepth = Entries * Window;
  localparam int unsigned RW = $clog2(RingDepth) > 0 ? $clog2(RingDepth) : 1;
  localparam int unsigned CW = $clog2(Window + 1);
  localparam int unsigned NP = 1 << EW;
  localparam logic signed [4:0] IdleMin = -5'sd16;

  logic              act_q;
  logic [IdW-1:0]    id_q;
  logic [31:0]       rb_q, wb_q;
  logic [Entries-1:0] valid_q;
  logic [IdW-1:0]    key_q   [Entries];
  logic [HW-1:0]     head_q  [Entries];
  logic [SumW-1:0]   rtot_q  [Entries];
  logic [SumW-1:0]   wtot_q  [Entries];
  logic signed [4:0] idle_q  [Entries];
  logic [CW-1:0]     fill_q  [Entries];
  logic [EW-1:0]     slot_q;
  logic              alloc_q;

  logic [IdW-1:0] in_flow_sel;
  assign in_flow_sel = id_q;

  // key match and lowest free slot
  logic          hit, free_found;
  logic [EW-1:0] hit_idx, free_idx;
  always_comb begin
    hit = 1'b0; free_found = 1'b0; hit_idx = '0; free_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (valid_q[i] && key_q[i] == in_flow_sel) begin
        hit = 1'b1; hit_idx = EW'(i);
      end
      if (!valid_q[i]) begin
        free_found = 1'b1; free_idx = EW'(i);
      end
    end
  end

  // marked entry with lowest key (compare tree over the table, result registered)
  logic           nd_v [2*NP];
  logic [IdW-1:0] nd_k [2*NP];
  logic [EW-1:0]  nd_i [2*NP];
  logic           any_mark;
  logic [EW-1:0]  min_idx;
  logic           any_after;
  logic           seen;
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      nd_v[NP + i] = 1'b0;
      nd_k[NP + i] = '0;
      nd_i[NP + i] = EW'(i);
    end
    seen      = 1'b0;
    any_after = 1'b0;
    for (int i = 0; i < Entries; i++) begin
      if (valid_q[i] && idle_q[i] <= 5'sd0) begin
        nd_v[NP + i] = 1'b1;
        nd_k[NP + i] = key_q[i];
        any_after    = any_after | seen;
        seen         = 1'b1;
      end
    end
    for (int n = NP - 1; n >= 1; n--) begin
      if (nd_v[2*n] && (!nd_v[2*n+1] || nd_k[2*n] <= nd_k[2*n+1])) begin
        nd_v[n] = 1'b1; nd_k[n] = nd_k[2*n]; nd_i[n] = nd_i[2*n];
      end else begin
        nd_v[n] = nd_v[2*n+1]; nd_k[n] = nd_k[2*n+1]; nd_i[n] = nd_i[2*n+1];
      end
    end
    nd_v[0]  = 1'b0;
    nd_k[0]  = '0;
    nd_i[0]  = '0;
    any_mark = nd_v[1];
    min_idx  = nd_i[1];
  end
  logic          more_q;

  assign sts_o.is_scan    = act_q;
  assign sts_o.hit        = hit;
  assign sts_o.free_found = free_found;
  assign sts_o.any_marked = any_mark;

  // ring memories, read address set at lookup
  logic          ring_we;
  logic [RW-1:0] ring_addr;
  logic [31:0]   old_r, old_w;
  logic [EW-1:0] lk_slot;
  assign lk_slot   = hit ? hit_idx : free_idx;
  assign ring_we   = cmd_i.update;
  assign ring_addr = cmd_i.update
      ? RW'(slot_q * Window + (alloc_q ? '0 : head_q[slot_q]))
      : RW'(lk_slot * Window + (hit ? head_q[hit_idx] : '0));

  pfwbs_ram #(.Width(32), .Depth(RingDepth)) u_rram (
    .clk_i, .we_i(ring_we), .addr_i(ring_addr), .wdata_i(rb_q), .rdata_o(old_r));
  pfwbs_ram #(.Width(32), .Depth(RingDepth)) u_wram (
    .clk_i, .we_i(ring_we), .addr_i(ring_addr), .wdata_i(wb_q), .rdata_o(old_w));

  // entry values after allocation
  logic [HW-1:0]     c_head;
  logic [SumW-1:0]   c_rt, c_wt, n_rt, n_wt;
  logic signed [4:0] c_idle, n_idle;
  logic [CW-1:0]     c_fill, n_fill;
  logic              full;
  always_comb begin
    c_head = alloc_q ? '0 : head_q[slot_q];
    c_rt   = alloc_q ? '0 : rtot_q[slot_q];
    c_wt   = alloc_q ? '0 : wtot_q[slot_q];
    c_idle = alloc_q ? 5'sd0 : idle_q[slot_q];
    c_fill = alloc_q ? '0 : fill_q[slot_q];
    full   = c_fill >= CW'(Window);
    n_rt   = c_rt - (full ? SumW'(old_r) : '0) + SumW'(rb_q);
    n_wt   = c_wt - (full ? SumW'(old_w) : '0) + SumW'(wb_q);
    n_fill = full ? c_fill : c_fill + CW'(1);
    if (rb_q != '0 || wb_q != '0) n_idle = 5'(Window);
    else if (c_idle > IdleMin)    n_idle = c_idle - 5'sd1;
    else                          n_idle = c_idle;
  end

  // input capture, lookup and scan pick registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= in_action_i; id_q <= in_flow_id_i;
      rb_q <= in_read_bytes_i; wb_q <= in_write_bytes_i;
    end
    if (cmd_i.lookup) begin
      slot_q <= lk_slot; alloc_q <= !hit;
    end
    if (cmd_i.scan_pick) begin
      slot_q <= min_idx; more_q <= any_after;
    end
  end

  // table state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (cmd_i.update) valid_q[slot_q] <= 1'b1;
      if (cmd_i.evict)  valid_q[slot_q] <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      key_q[slot_q]  <= id_q;
      head_q[slot_q] <= (c_head == HW'(Window - 1)) ? '0 : c_head + HW'(1);
      rtot_q[slot_q] <= n_rt;
      wtot_q[slot_q] <= n_wt;
      idle_q[slot_q] <= n_idle;
      fill_q[slot_q] <= n_fill;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (emit_i) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      if (act_q) begin
        out_kind_o      <= KIND_EVICT;
        out_flow_o      <= key_q[slot_q];
        out_read_sum_o  <= rtot_q[slot_q];
        out_write_sum_o <= wtot_q[slot_q];
        out_fill_o      <= FillW'(fill_q[slot_q]);
        out_last_o      <= !more_q;
      end else if (cmd_i.update) begin
        out_kind_o      <= KIND_UPDATE;
        out_flow_o      <= id_q;
        out_read_sum_o  <= n_rt;
        out_write_sum_o <= n_wt;
        out_fill_o      <= FillW'(n_fill);
        out_last_o      <= 1'b1;
      end else begin
        out_kind_o      <= KIND_DROP;
        out_flow_o      <= id_q;
        out_read_sum_o  <= '0;
        out_write_sum_o <= '0;
        out_fill_o      <= '0;
        out_last_o      <= 1'b1;
      end
    end
  end

  `PFW_ASSERT(a_evict_valid, clk_i, rst_ni, cmd_i.evict |-> valid_q[slot_q])
  `PFW_ASSERT_NEXT(a_evict_clr, clk_i, rst_ni, cmd_i.evict, !valid_q[$past(slot_q)])
  `PFW_ASSERT_NEXT(a_upd_set, clk_i, rst_ni, cmd_i.update, valid_q[$past(slot_q)])
endmodule
